>>> hw/rtl/dra_pkg.sv
package dra_pkg;

   localparam int HEAP_SLOTS  = 1024;
   localparam int MAX_BLOCKS  = 64;
   localparam int BLK_AW      = $clog2(MAX_BLOCKS);
   localparam int STALE_DEPTH = 16;
   localparam int STALE_AW    = $clog2(STALE_DEPTH);

   typedef struct packed {
      logic [9:0]  start;
      logic [10:0] len;
      logic [15:0] stamp;
   } blk_type;

   typedef struct packed {
      logic [9:0]  start;
      logic [10:0] len;
   } stale_type;

   typedef enum logic [1:0] {
      MODE_ALLOC, MODE_FREE, MODE_RELEASE, MODE_NONE
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK, ST_NOFIT, ST_FULL, ST_BADCNT
   } status_type;

   typedef enum logic [2:0] {
      S_INIT, S_IDLE, S_SLOAD, S_SCAN, S_PUT, S_FIN
   } state_type;

   typedef enum logic {
      OP_ALLOC, OP_RELEASE
   } op_type;

   typedef struct packed {
      logic        wr;
      logic [10:0] wdata;
      logic [10:0] heap;
   } cfg_type;

   function automatic logic [10:0] eff_heap(input logic [10:0] h);
      return (h > 11'(HEAP_SLOTS)) ? 11'(HEAP_SLOTS) : h;
   endfunction

endpackage

>>> hw/rtl/dra_ram.sv
module dra_ram #(
   parameter int W  = 8,
   parameter int D  = 16,
   parameter int AW = $clog2(D)
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [W-1:0]  wdata,
   input  logic [AW-1:0] raddr,
   output logic [W-1:0]  rdata
);

   logic [W-1:0] mem [D];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end

endmodule

>>> hw/rtl/dra_csr.sv
module dra_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output dra_pkg::cfg_type cfg
);

   logic [10:0] heap_ff, heap_in;
   logic        wr;

   assign wr         = csr_psel && csr_penable && csr_pwrite && !csr_paddr[2];
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {21'd0, heap_ff};

   always_comb begin
      heap_in = heap_ff;
      if (wr) begin
         heap_in = csr_pwdata[10:0];
      end
      cfg.wr    = wr;
      cfg.wdata = csr_pwdata[10:0];
      cfg.heap  = heap_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_ff <= 11'(dra_pkg::HEAP_SLOTS);
      end else begin
         heap_ff <= heap_in;
      end
   end

endmodule

>>> hw/rtl/dra_engine.sv
module dra_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  dra_pkg::cfg_type              cfg,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  dra_pkg::mode_type             req_mode,
   input  logic [10:0]                   req_count,
   input  logic [9:0]                    req_start,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output dra_pkg::status_type           rsp_status,
   output logic [9:0]                    rsp_granted,
   output logic [10:0]                   rsp_free,
   output logic                          tw_en,
   output logic [dra_pkg::BLK_AW-1:0]    tw_addr,
   output dra_pkg::blk_type              tw_data,
   output logic [dra_pkg::BLK_AW-1:0]    tr_addr,
   input  dra_pkg::blk_type              tr_data,
   output logic                          sw_en,
   output logic [dra_pkg::STALE_AW-1:0]  sw_addr,
   output dra_pkg::stale_type            sw_data,
   output logic [dra_pkg::STALE_AW-1:0]  sr_addr,
   input  dra_pkg::stale_type            sr_data
);

   localparam int NB = dra_pkg::MAX_BLOCKS;
   localparam int BA = dra_pkg::BLK_AW;

   dra_pkg::state_type  state_ff, state_in;
   dra_pkg::op_type     op_ff, op_in;
   logic                ren_ff, ren_in;
   logic [10:0]         cnt_ff, cnt_in;
   logic [BA:0]         scan_ff, scan_in;
   logic                pv_ff, pv_in;
   logic [BA-1:0]       pidx_ff, pidx_in;
   dra_pkg::blk_type    a_ff, a_in, b_ff, b_in;
   logic [BA-1:0]       a_idx_ff, a_idx_in, b_idx_ff, b_idx_in, e_idx_ff, e_idx_in;
   logic                a_fnd_ff, a_fnd_in, b_fnd_ff, b_fnd_in, e_fnd_ff, e_fnd_in;
   logic [NB-1:0]       valid_ff, valid_in, done_ff, done_in;
   logic [BA:0]         k_ff, k_in;
   logic [15:0]         stamp_ff, stamp_in;
   logic [10:0]         free_ff, free_in;
   logic [dra_pkg::STALE_AW-1:0] head_ff, head_in;
   logic [dra_pkg::STALE_AW:0]   fill_ff, fill_in;
   logic [9:0]          put_start_ff, put_start_in;
   logic [10:0]         put_len_ff, put_len_in;
   logic [BA-1:0]       put_idx_ff, put_idx_in;
   dra_pkg::status_type st_ff, st_in, rst_ff, rst_in;
   logic [9:0]          gr_ff, gr_in, rgr_ff, rgr_in;
   logic [10:0]         rfree_ff, rfree_in;
   logic                rv_ff, rv_in;

   logic        v;
   logic        scan_end;
   logic        mp, mn;
   logic [11:0] end_r, fsum;
   logic [10:0] heap_eff, reb_e, rest;
   logic [BA:0] pi;

   assign req_ready   = (state_ff == dra_pkg::S_IDLE);
   assign rsp_valid   = rv_ff;
   assign rsp_status  = rst_ff;
   assign rsp_granted = rgr_ff;
   assign rsp_free    = rfree_ff;
   assign tr_addr     = scan_ff[BA-1:0];
   assign sr_addr     = head_ff;

   always_comb begin
      state_in = state_ff;  op_in = op_ff;  ren_in = ren_ff;  cnt_in = cnt_ff;
      scan_in = scan_ff;  pv_in = 1'b0;  pidx_in = pidx_ff;
      a_in = a_ff;  a_idx_in = a_idx_ff;  a_fnd_in = a_fnd_ff;
      b_in = b_ff;  b_idx_in = b_idx_ff;  b_fnd_in = b_fnd_ff;
      e_idx_in = e_idx_ff;  e_fnd_in = e_fnd_ff;
      valid_in = valid_ff;  done_in = done_ff;  k_in = k_ff;
      stamp_in = stamp_ff;  free_in = free_ff;  head_in = head_ff;  fill_in = fill_ff;
      put_start_in = put_start_ff;  put_len_in = put_len_ff;  put_idx_in = put_idx_ff;
      st_in = st_ff;  gr_in = gr_ff;
      rst_in = rst_ff;  rgr_in = rgr_ff;  rfree_in = rfree_ff;  rv_in = rv_ff;
      tw_en = 1'b0;  tw_addr = '0;  tw_data = '0;
      sw_en = 1'b0;  sw_addr = head_ff + fill_ff[dra_pkg::STALE_AW-1:0];
      sw_data = '{start: req_start, len: req_count};

      heap_eff = dra_pkg::eff_heap(cfg.heap);
      v        = valid_ff[pidx_ff];
      scan_end = (scan_ff == (BA+1)'(NB)) && !pv_ff;
      end_r    = {2'd0, sr_data.start} + {1'b0, sr_data.len};
      mp       = a_fnd_ff && (({2'd0, a_ff.start} + {1'b0, a_ff.len}) == {2'd0, sr_data.start});
      mn       = b_fnd_ff && (end_r == {2'd0, b_ff.start});
      fsum     = {1'b0, free_ff} + {1'b0, sr_data.len};
      rest     = a_ff.len - cnt_ff;
      pi       = '1;
      if (e_fnd_ff) begin
         pi = {1'b0, e_idx_ff};
      end
      if (mp && ({1'b0, a_idx_ff} < pi)) begin
         pi = {1'b0, a_idx_ff};
      end
      if (mn && ({1'b0, b_idx_ff} < pi)) begin
         pi = {1'b0, b_idx_ff};
      end

      if (rv_ff && rsp_ready) begin
         rv_in = 1'b0;
      end

      case (state_ff)
         dra_pkg::S_INIT: begin
            state_in = dra_pkg::S_IDLE;
         end
         dra_pkg::S_IDLE: begin
            if (req_valid) begin
               gr_in    = '0;
               st_in    = dra_pkg::ST_OK;
               state_in = dra_pkg::S_FIN;
               cnt_in   = req_count;
               case (req_mode)
                  dra_pkg::MODE_ALLOC: begin
                     if (req_count == '0) begin
                        st_in = dra_pkg::ST_BADCNT;
                     end else if (req_count > free_ff) begin
                        st_in = dra_pkg::ST_NOFIT;
                     end else begin
                        op_in = dra_pkg::OP_ALLOC;  ren_in = 1'b0;
                        scan_in = '0;  a_fnd_in = 1'b0;
                        state_in = dra_pkg::S_SCAN;
                     end
                  end
                  dra_pkg::MODE_FREE: begin
                     if (req_count == '0 ||
                         ({2'd0, req_start} + {1'b0, req_count}) > {1'b0, heap_eff}) begin
                        st_in = dra_pkg::ST_BADCNT;
                     end else if (fill_ff[dra_pkg::STALE_AW]) begin
                        st_in = dra_pkg::ST_FULL;
                     end else begin
                        sw_en   = 1'b1;
                        fill_in = fill_ff + 1'b1;
                     end
                  end
                  dra_pkg::MODE_RELEASE: begin
                     if (fill_ff != '0) begin
                        op_in = dra_pkg::OP_RELEASE;  ren_in = 1'b0;
                        state_in = dra_pkg::S_SLOAD;
                     end
                  end
                  default: begin
                     st_in = dra_pkg::ST_BADCNT;
                  end
               endcase
            end
         end
         dra_pkg::S_SLOAD: begin
            scan_in = '0;  a_fnd_in = 1'b0;  b_fnd_in = 1'b0;  e_fnd_in = 1'b0;
            state_in = dra_pkg::S_SCAN;
         end
         dra_pkg::S_SCAN: begin
            if (scan_ff != (BA+1)'(NB)) begin
               scan_in = scan_ff + 1'b1;
               pv_in   = 1'b1;
               pidx_in = scan_ff[BA-1:0];
            end
            if (pv_ff) begin
               if (ren_ff) begin
                  if (v && !done_ff[pidx_ff] && (!a_fnd_ff || tr_data.stamp < a_ff.stamp)) begin
                     a_in = tr_data;  a_idx_in = pidx_ff;  a_fnd_in = 1'b1;
                  end
               end else if (op_ff == dra_pkg::OP_ALLOC) begin
                  if (v && tr_data.len >= cnt_ff && (!a_fnd_ff || tr_data.len < a_ff.len ||
                      (tr_data.len == a_ff.len && tr_data.stamp < a_ff.stamp))) begin
                     a_in = tr_data;  a_idx_in = pidx_ff;  a_fnd_in = 1'b1;
                  end
               end else begin
                  if (!v && !e_fnd_ff) begin
                     e_fnd_in = 1'b1;  e_idx_in = pidx_ff;
                  end
                  if (v && tr_data.start > sr_data.start) begin
                     if (!b_fnd_ff || tr_data.start < b_ff.start ||
                         (tr_data.start == b_ff.start && tr_data.stamp < b_ff.stamp)) begin
                        b_in = tr_data;  b_idx_in = pidx_ff;  b_fnd_in = 1'b1;
                     end
                  end else if (v) begin
                     if (!a_fnd_ff || tr_data.start > a_ff.start ||
                         (tr_data.start == a_ff.start && tr_data.stamp > a_ff.stamp)) begin
                        a_in = tr_data;  a_idx_in = pidx_ff;  a_fnd_in = 1'b1;
                     end
                  end
               end
            end
            if (scan_end) begin
               if (ren_ff) begin
                  if (a_fnd_ff) begin
                     tw_en   = 1'b1;
                     tw_addr = a_idx_ff;
                     tw_data = '{start: a_ff.start, len: a_ff.len, stamp: 16'(k_ff)};
                     done_in[a_idx_ff] = 1'b1;
                     k_in    = k_ff + 1'b1;
                     scan_in = '0;  a_fnd_in = 1'b0;
                  end else begin
                     stamp_in = 16'(k_ff);
                     ren_in   = 1'b0;
                     state_in = dra_pkg::S_PUT;
                  end
               end else if (op_ff == dra_pkg::OP_ALLOC) begin
                  if (!a_fnd_ff) begin
                     st_in    = dra_pkg::ST_NOFIT;
                     state_in = dra_pkg::S_FIN;
                  end else begin
                     valid_in[a_idx_ff] = 1'b0;
                     free_in = free_ff - cnt_ff;
                     gr_in   = a_ff.start;
                     put_idx_in   = a_idx_ff;
                     put_start_in = a_ff.start + cnt_ff[9:0];
                     put_len_in   = rest;
                     st_in        = dra_pkg::ST_OK;
                     state_in     = (rest != '0) ? dra_pkg::S_PUT : dra_pkg::S_FIN;
                  end
               end else begin
                  if (!mp && !e_fnd_ff && !mn) begin
                     st_in    = dra_pkg::ST_FULL;
                     state_in = dra_pkg::S_FIN;
                  end else begin
                     free_in = (fsum > {1'b0, heap_eff}) ? heap_eff : fsum[10:0];
                     put_start_in = mp ? a_ff.start : sr_data.start;
                     put_len_in   = sr_data.len + (mp ? a_ff.len : 11'd0)
                                    + (mn ? b_ff.len : 11'd0);
                     if (mp) begin
                        valid_in[a_idx_ff] = 1'b0;
                     end
                     if (mn) begin
                        valid_in[b_idx_ff] = 1'b0;
                     end
                     put_idx_in = pi[BA-1:0];
                     state_in   = dra_pkg::S_PUT;
                  end
               end
            end
         end
         dra_pkg::S_PUT: begin
            if (stamp_ff == 16'hFFFF) begin
               ren_in  = 1'b1;
               done_in = '0;
               k_in    = '0;
               scan_in = '0;  a_fnd_in = 1'b0;
               state_in = dra_pkg::S_SCAN;
            end else begin
               tw_en   = 1'b1;
               tw_addr = put_idx_ff;
               tw_data = '{start: put_start_ff, len: put_len_ff, stamp: stamp_ff};
               valid_in[put_idx_ff] = 1'b1;
               stamp_in = stamp_ff + 1'b1;
               if (op_ff == dra_pkg::OP_ALLOC) begin
                  state_in = dra_pkg::S_FIN;
               end else begin
                  head_in = head_ff + 1'b1;
                  fill_in = fill_ff - 1'b1;
                  state_in = (fill_ff == 1) ? dra_pkg::S_FIN : dra_pkg::S_SLOAD;
               end
            end
         end
         dra_pkg::S_FIN: begin
            if (!rv_ff || rsp_ready) begin
               rv_in    = 1'b1;
               rst_in   = st_ff;
               rgr_in   = gr_ff;
               rfree_in = free_ff;
               state_in = dra_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = dra_pkg::S_IDLE;
         end
      endcase

      // table rebuild after reset or a heap size write
      reb_e = dra_pkg::eff_heap(cfg.wr ? cfg.wdata : cfg.heap);
      if (cfg.wr || state_ff == dra_pkg::S_INIT) begin
         valid_in    = '0;
         valid_in[0] = (reb_e != '0);
         tw_en    = 1'b1;
         tw_addr  = '0;
         tw_data  = '{start: 10'd0, len: reb_e, stamp: 16'd0};
         stamp_in = 16'd1;
         free_in  = reb_e;
         head_in  = '0;
         fill_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dra_pkg::S_INIT;
         ren_ff   <= 1'b0;
         pv_ff    <= 1'b0;
         valid_ff <= '0;
         stamp_ff <= 16'd1;
         free_ff  <= '0;
         head_ff  <= '0;
         fill_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ren_ff   <= ren_in;
         pv_ff    <= pv_in;
         valid_ff <= valid_in;
         stamp_ff <= stamp_in;
         free_ff  <= free_in;
         head_ff  <= head_in;
         fill_ff  <= fill_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;  cnt_ff <= cnt_in;  scan_ff <= scan_in;  pidx_ff <= pidx_in;
      a_ff <= a_in;  a_idx_ff <= a_idx_in;  a_fnd_ff <= a_fnd_in;
      b_ff <= b_in;  b_idx_ff <= b_idx_in;  b_fnd_ff <= b_fnd_in;
      e_idx_ff <= e_idx_in;  e_fnd_ff <= e_fnd_in;
      done_ff <= done_in;  k_ff <= k_in;
      put_start_ff <= put_start_in;  put_len_ff <= put_len_in;  put_idx_ff <= put_idx_in;
      st_ff <= st_in;  gr_ff <= gr_in;
      rst_ff <= rst_in;  rgr_ff <= rgr_in;  rfree_ff <= rfree_in;
   end

endmodule

>>> hw/rtl/descriptor_range_allocator_top.sv
// allocate scans the table once, release scans it once per queued range; requests rejected
// on entry and free requests skip the scan; each then waits for the result register to be free
// one request at a time, set by the 64 entry table scan through one read port
// stamp renumbering, about once in 65k block inserts, rescans the table for each valid block
// reset: synchronous; the S_INIT state after reset loads entry 0 with the whole heap
module descriptor_range_allocator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // count[10:0], start_slot[20:11], zero pad
   input  logic [1:0]  req_tuser,   // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // granted_slot[9:0], free_total[20:10], zero pad
   output logic [1:0]  rsp_tuser,   // status[1:0]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   dra_pkg::cfg_type    cfg;
   dra_pkg::status_type status;
   logic [9:0]          granted;
   logic [10:0]         free_total;
   logic                tw_en, sw_en;
   logic [dra_pkg::BLK_AW-1:0]   tw_addr, tr_addr;
   logic [dra_pkg::STALE_AW-1:0] sw_addr, sr_addr;
   dra_pkg::blk_type    tw_data, tr_data;
   dra_pkg::stale_type  sw_data, sr_data;

   dra_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .cfg
   );

   dra_ram #(.W($bits(dra_pkg::blk_type)), .D(dra_pkg::MAX_BLOCKS)) u_tbl (
      .clock, .we(tw_en), .waddr(tw_addr), .wdata(tw_data), .raddr(tr_addr), .rdata(tr_data)
   );

   dra_ram #(.W($bits(dra_pkg::stale_type)), .D(dra_pkg::STALE_DEPTH)) u_stale (
      .clock, .we(sw_en), .waddr(sw_addr), .wdata(sw_data), .raddr(sr_addr), .rdata(sr_data)
   );

   dra_engine u_eng (
      .clock, .reset, .cfg,
      .req_valid(req_tvalid), .req_ready(req_tready),
      .req_mode(dra_pkg::mode_type'(req_tuser)),
      .req_count(req_tdata[10:0]), .req_start(req_tdata[20:11]),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready),
      .rsp_status(status), .rsp_granted(granted), .rsp_free(free_total),
      .tw_en, .tw_addr, .tw_data, .tr_addr, .tr_data,
      .sw_en, .sw_addr, .sw_data, .sr_addr, .sr_data
   );

   assign rsp_tdata = {3'd0, free_total, granted};
   assign rsp_tuser = status;

endmodule

>>> hw/rtl/dra_checker.sv
module dra_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != dra_pkg::ST_OK) |-> rsp_tdata[9:0] == 10'd0)
      else $error("granted slot set on a failed request");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[20:10] <= 11'(dra_pkg::HEAP_SLOTS))
      else $error("free total above heap");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind descriptor_range_allocator_top dra_checker u_chk (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
);

>>> test/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 3000000;

   typedef struct {
      dra_pkg::status_type st;
      logic [9:0]          granted;
      logic [10:0]         free_total;
   } outcome_type;

   typedef struct {
      dra_pkg::mode_type   mode;
      int unsigned         cnt;
      int unsigned         slot;
      bit                  fixed;
      dra_pkg::status_type st;
      int unsigned         granted;
      int unsigned         free_total;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   descriptor_range_allocator_top dut (.*);

   always #6 clock = ~clock;

   // model of the free table and stale queue
   logic [9:0]  fb_start [dra_pkg::MAX_BLOCKS];
   logic [10:0] fb_len [dra_pkg::MAX_BLOCKS];
   bit          fb_valid [dra_pkg::MAX_BLOCKS];
   int unsigned fb_stamp [dra_pkg::MAX_BLOCKS];
   int unsigned stamp_ctr, free_cnt, heap_eff;
   int unsigned sq_start [dra_pkg::STALE_DEPTH];
   int unsigned sq_len [dra_pkg::STALE_DEPTH];
   int unsigned sq_head, sq_fill;

   outcome_type expected_q [$];
   int unsigned live_off [$];
   int unsigned live_len [$];
   int          fails = 0;
   int          cycles = 0;
   bit          req_took = 1'b0;
   bit          cur_fixed = 1'b0;
   outcome_type cur_fixed_res;
   int          send_idle = 0;
   int          rsp_stall = 0;
   int          hold_cycles = 0;

   function automatic void heap_reset(input int unsigned h);
      heap_eff = (h > dra_pkg::HEAP_SLOTS) ? dra_pkg::HEAP_SLOTS : h;
      for (int i = 0; i < dra_pkg::MAX_BLOCKS; i++) begin
         fb_valid[i] = 1'b0;
         fb_start[i] = '0;
         fb_len[i] = '0;
         fb_stamp[i] = 0;
      end
      if (heap_eff > 0) begin
         fb_len[0] = 11'(heap_eff);
         fb_valid[0] = 1'b1;
      end
      stamp_ctr = 1;
      free_cnt = heap_eff;
      sq_head = 0;
      sq_fill = 0;
      live_off.delete();
      live_len.delete();
   endfunction

   function automatic int unsigned next_stamp();
      int unsigned rank [dra_pkg::MAX_BLOCKS];
      int unsigned n, s;
      if (stamp_ctr >= 16'hFFFF) begin
         n = 0;
         for (int i = 0; i < dra_pkg::MAX_BLOCKS; i++) begin
            rank[i] = 0;
            if (fb_valid[i]) begin
               n++;
               for (int j = 0; j < dra_pkg::MAX_BLOCKS; j++)
                  if (fb_valid[j] && fb_stamp[j] < fb_stamp[i]) rank[i]++;
            end
         end
         for (int i = 0; i < dra_pkg::MAX_BLOCKS; i++)
            if (fb_valid[i]) fb_stamp[i] = rank[i];
         stamp_ctr = n;
      end
      s = stamp_ctr;
      stamp_ctr = (stamp_ctr + 1) & 16'hFFFF;
      return s;
   endfunction

   function automatic int vacant_entry();
      for (int i = 0; i < dra_pkg::MAX_BLOCKS; i++)
         if (!fb_valid[i]) return i;
      return -1;
   endfunction

   function automatic void insert_block(input int idx, input int unsigned off, len);
      fb_start[idx] = 10'(off);
      fb_len[idx] = 11'(len);
      fb_stamp[idx] = next_stamp();
      fb_valid[idx] = 1'b1;
   endfunction

   function automatic bit coalesce_range(input int unsigned off_in, len_in);
      int unsigned off, len;
      int prv, nxt;
      bit mp, mn;
      off = off_in;
      len = len_in;
      prv = -1;
      nxt = -1;
      for (int i = 0; i < dra_pkg::MAX_BLOCKS; i++) begin
         if (!fb_valid[i]) continue;
         if (fb_start[i] > off) begin
            if (nxt < 0 || fb_start[i] < fb_start[nxt] ||
                (fb_start[i] == fb_start[nxt] && fb_stamp[i] < fb_stamp[nxt])) nxt = i;
         end else begin
            if (prv < 0 || fb_start[i] > fb_start[prv] ||
                (fb_start[i] == fb_start[prv] && fb_stamp[i] > fb_stamp[prv])) prv = i;
         end
      end
      mp = prv >= 0 && (fb_start[prv] + fb_len[prv] == off);
      if (!mp && vacant_entry() < 0) begin
         mn = nxt >= 0 && (off + len == fb_start[nxt]);
         if (!mn) return 1'b0;
      end
      free_cnt += len;
      if (free_cnt > heap_eff) free_cnt = heap_eff;
      if (mp) begin
         off = fb_start[prv];
         len += fb_len[prv];
         fb_valid[prv] = 1'b0;
      end
      mn = nxt >= 0 && (off + len == fb_start[nxt]);
      if (mn) begin
         len += fb_len[nxt];
         fb_valid[nxt] = 1'b0;
      end
      insert_block(vacant_entry(), off, len);
      return 1'b1;
   endfunction

   function automatic outcome_type predict_request(input dra_pkg::mode_type m,
                                                   input int unsigned cnt, slot);
      outcome_type r;
      int best;
      int unsigned off, rest;
      r.st = dra_pkg::ST_OK;
      r.granted = '0;
      case (m)
         dra_pkg::MODE_ALLOC: begin
            if (cnt == 0) r.st = dra_pkg::ST_BADCNT;
            else if (cnt > free_cnt) r.st = dra_pkg::ST_NOFIT;
            else begin
               best = -1;
               for (int i = 0; i < dra_pkg::MAX_BLOCKS; i++) begin
                  if (!fb_valid[i] || fb_len[i] < cnt) continue;
                  if (best < 0 || fb_len[i] < fb_len[best] ||
                      (fb_len[i] == fb_len[best] && fb_stamp[i] < fb_stamp[best])) best = i;
               end
               if (best < 0) r.st = dra_pkg::ST_NOFIT;
               else begin
                  off = fb_start[best];
                  rest = fb_len[best] - cnt;
                  fb_valid[best] = 1'b0;
                  if (rest > 0) insert_block(best, off + cnt, rest);
                  free_cnt -= cnt;
                  r.granted = 10'(off);
                  live_off.push_back(off);
                  live_len.push_back(cnt);
               end
            end
         end
         dra_pkg::MODE_FREE: begin
            if (cnt == 0 || slot + cnt > heap_eff) r.st = dra_pkg::ST_BADCNT;
            else if (sq_fill >= dra_pkg::STALE_DEPTH) r.st = dra_pkg::ST_FULL;
            else begin
               sq_start[(sq_head + sq_fill) % dra_pkg::STALE_DEPTH] = slot;
               sq_len[(sq_head + sq_fill) % dra_pkg::STALE_DEPTH] = cnt;
               sq_fill++;
            end
         end
         dra_pkg::MODE_RELEASE: begin
            while (sq_fill > 0) begin
               if (!coalesce_range(sq_start[sq_head], sq_len[sq_head])) begin
                  r.st = dra_pkg::ST_FULL;
                  break;
               end
               sq_head = (sq_head + 1) % dra_pkg::STALE_DEPTH;
               sq_fill--;
            end
         end
         default: r.st = dra_pkg::ST_BADCNT;
      endcase
      r.free_total = 11'(free_cnt);
      return r;
   endfunction

   always @(posedge clock) begin
      outcome_type p, e;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else if (!reset) begin
         if (req_tvalid && req_tready) begin
            p = predict_request(dra_pkg::mode_type'(req_tuser), req_tdata[10:0],
                                req_tdata[20:11]);
            expected_q.push_back(cur_fixed ? cur_fixed_res : p);
            req_took = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               $display("%t: response with none expected: status %0d data %h",
                        $time, rsp_tuser, rsp_tdata);
               fails++;
            end else begin
               e = expected_q.pop_front();
               if (rsp_tuser != e.st) begin
                  $display("%t: status expected %0d actual %0d", $time, e.st, rsp_tuser);
                  fails++;
               end
               if (rsp_tdata[9:0] != e.granted) begin
                  $display("%t: granted_slot expected %0d actual %0d",
                           $time, e.granted, rsp_tdata[9:0]);
                  fails++;
               end
               if (rsp_tdata[20:10] != e.free_total) begin
                  $display("%t: free_total expected %0d actual %0d",
                           $time, e.free_total, rsp_tdata[20:10]);
                  fails++;
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall);
      end
   end

   task automatic put_request(input dra_pkg::mode_type m, input int unsigned cnt, slot);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tuser = m;
      req_tdata = {3'b000, 10'(slot), 11'(cnt)};
      req_tvalid = 1'b1;
      req_took = 1'b0;
      do @(negedge clock); while (!req_took);
      req_took = 1'b0;
   endtask

   task automatic drain_results();
      req_tvalid = 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_heap_size(input int unsigned h);
      drain_results();
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_paddr = '0;
      csr_pwdata = h;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      heap_reset(h & 11'h7FF);
   endtask

   task automatic random_requests(input int n);
      int r, k;
      int unsigned cnt, slot;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 40 || r >= 90) begin
            k = $urandom_range(99);
            if (k < 70) cnt = $urandom_range(24, 1);
            else if (k < 90) cnt = $urandom_range(heap_eff > 1 ? heap_eff : 1, 1);
            else if (k < 95) cnt = 0;
            else cnt = $urandom_range(2047, 1025);
            put_request(dra_pkg::MODE_ALLOC, cnt, $urandom_range(1023));
         end else if (r < 75) begin
            if (live_off.size() != 0 && $urandom_range(99) < 85) begin
               k = $urandom_range(live_off.size() - 1);
               slot = live_off[k];
               cnt = live_len[k];
               live_off.delete(k);
               live_len.delete(k);
            end else begin
               slot = $urandom_range(1023);
               cnt = $urandom_range(40);
            end
            put_request(dra_pkg::MODE_FREE, cnt, slot);
         end else if (r < 88) begin
            put_request(dra_pkg::MODE_RELEASE, $urandom_range(2047), $urandom_range(1023));
         end else begin
            put_request(dra_pkg::MODE_NONE, $urandom_range(2047), $urandom_range(1023));
         end
      end
   endtask

   row_type directed [] = '{
      '{dra_pkg::MODE_ALLOC,      0,    0, 1'b1, dra_pkg::ST_BADCNT, 0, 1024},
      '{dra_pkg::MODE_ALLOC,   1025,    0, 1'b1, dra_pkg::ST_NOFIT,  0, 1024},
      '{dra_pkg::MODE_ALLOC,   2047, 1023, 1'b1, dra_pkg::ST_NOFIT,  0, 1024},
      '{dra_pkg::MODE_NONE,       5,    5, 1'b1, dra_pkg::ST_BADCNT, 0, 1024},
      '{dra_pkg::MODE_FREE,       0,    3, 1'b1, dra_pkg::ST_BADCNT, 0, 1024},
      '{dra_pkg::MODE_FREE,       2, 1023, 1'b1, dra_pkg::ST_BADCNT, 0, 1024},
      '{dra_pkg::MODE_RELEASE,    0,    0, 1'b1, dra_pkg::ST_OK,     0, 1024},
      '{dra_pkg::MODE_ALLOC,   1024,    0, 1'b1, dra_pkg::ST_OK,     0,    0},
      '{dra_pkg::MODE_ALLOC,      1,    0, 1'b1, dra_pkg::ST_NOFIT,  0,    0},
      '{dra_pkg::MODE_FREE,    1024,    0, 1'b1, dra_pkg::ST_OK,     0,    0},
      '{dra_pkg::MODE_RELEASE,    0,    0, 1'b1, dra_pkg::ST_OK,     0, 1024},
      '{dra_pkg::MODE_ALLOC,    100,    0, 1'b1, dra_pkg::ST_OK,     0,  924},
      '{dra_pkg::MODE_ALLOC,     50,    0, 1'b1, dra_pkg::ST_OK,   100,  874},
      '{dra_pkg::MODE_FREE,     100,    0, 1'b1, dra_pkg::ST_OK,     0,  874},
      '{dra_pkg::MODE_RELEASE,    0,    0, 1'b1, dra_pkg::ST_OK,     0,  974},
      '{dra_pkg::MODE_ALLOC,    100,    0, 1'b1, dra_pkg::ST_OK,     0,  874},
      '{dra_pkg::MODE_FREE,       1, 1023, 1'b0, dra_pkg::ST_OK,     0,    0},
      '{dra_pkg::MODE_FREE,      50,  100, 1'b0, dra_pkg::ST_OK,     0,    0},
      '{dra_pkg::MODE_FREE,      50,  100, 1'b0, dra_pkg::ST_OK,     0,    0},
      '{dra_pkg::MODE_RELEASE,    0,    0, 1'b0, dra_pkg::ST_OK,     0,    0},
      '{dra_pkg::MODE_ALLOC,    923,    0, 1'b0, dra_pkg::ST_OK,     0,    0},
      '{dra_pkg::MODE_ALLOC,      1,    0, 1'b0, dra_pkg::ST_OK,     0,    0},
      '{dra_pkg::MODE_NONE,    2047, 1023, 1'b0, dra_pkg::ST_OK,     0,    0}
   };

   initial begin
      heap_reset(dra_pkg::HEAP_SLOTS);
      repeat (11) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      foreach (directed[i]) begin
         cur_fixed = directed[i].fixed;
         cur_fixed_res.st = directed[i].st;
         cur_fixed_res.granted = 10'(directed[i].granted);
         cur_fixed_res.free_total = 11'(directed[i].free_total);
         put_request(directed[i].mode, directed[i].cnt, directed[i].slot);
      end
      cur_fixed = 1'b0;

      write_heap_size(1024);
      random_requests(300);

      write_heap_size(2047);
      send_idle = 55;
      random_requests(250);

      write_heap_size(37);
      send_idle = 0;
      rsp_stall = 55;
      random_requests(250);

      write_heap_size(1);
      send_idle = 20;
      rsp_stall = 20;
      random_requests(80);

      write_heap_size(0);
      random_requests(30);

      // fragment the heap until the table overflows and the stale queue fills
      write_heap_size(200);
      send_idle = 0;
      rsp_stall = 0;
      for (int i = 0; i < 200; i++) put_request(dra_pkg::MODE_ALLOC, 1, 0);
      for (int i = 0; i < 100; i++) begin
         put_request(dra_pkg::MODE_FREE, 1, 2 * i);
         if (i % 16 == 15) put_request(dra_pkg::MODE_RELEASE, 0, 0);
      end
      put_request(dra_pkg::MODE_RELEASE, 0, 0);
      live_off.delete();
      live_len.delete();

      // long receiver hold-off so the request side backs up
      write_heap_size(1024);
      hold_cycles = 600;
      random_requests(40);
      drain_results();
      repeat (80) @(negedge clock);

      send_idle = 20;
      rsp_stall = 20;
      random_requests(120);
      send_idle = 0;
      rsp_stall = 0;
      random_requests(100);

      drain_results();
      repeat (200) @(negedge clock);
      if (fails == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/dra_pkg.sv
hw/rtl/dra_ram.sv
hw/rtl/dra_csr.sv
hw/rtl/dra_engine.sv
hw/rtl/descriptor_range_allocator_top.sv
hw/rtl/dra_checker.sv
test/tb.sv
